>>> sv/qvt_pkg.sv
// Shared types, widths and register codes for the quaternion vertex transform.
// No dependencies; every other file takes names from here by scope.
package qvt_pkg;

    localparam int COORD_W  = 16;
    localparam int QUAT_W   = 16;
    localparam int SCALE_W  = 16;
    localparam int CFG_DATA_W = (COORD_W > QUAT_W) ? COORD_W : QUAT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int TDATA_W  = ((3 * COORD_W + 7) / 8) * 8;

    // cross product terms q*v and their difference
    localparam int P1_W    = COORD_W + QUAT_W;
    localparam int C_W     = P1_W + 1;
    // t = 2*c rounded to 2^-12: (c + 2^8) >>> 9
    localparam int T_SHIFT = 9;
    localparam int T_W     = C_W + 1 - T_SHIFT;
    // second stage products and accumulator, units 2^-26
    localparam int P2_W    = QUAT_W + T_W;
    localparam int ACC_W   = P2_W + 3;
    localparam int V_SHIFT = 18;
    localparam int R_SHIFT = 14;
    localparam int R_W     = ACC_W - R_SHIFT;
    // scale product, units 2^-24
    localparam int SP_W    = R_W + SCALE_W + 1;
    localparam int S_W     = SP_W + 1;
    localparam int O_SHIFT = 16;
    localparam int OFF_SHIFT = 16;
    localparam int O_W     = S_W - O_SHIFT;

    localparam logic signed [C_W:0]     T_RND = (C_W + 1)'(1) <<< (T_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] R_RND = ACC_W'(1) <<< (R_SHIFT - 1);
    localparam logic signed [S_W-1:0]   O_RND = S_W'(1) <<< (O_SHIFT - 1);
    localparam logic signed [O_W-1:0]   O_MAX = (O_W'(1) <<< (COORD_W - 1)) - O_W'(1);
    localparam logic signed [O_W-1:0]   O_MIN = -(O_W'(1) <<< (COORD_W - 1));

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [R_W-1:0]     rot_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_W    = 3'd0,
        REG_ROT_X    = 3'd1,
        REG_ROT_Y    = 3'd2,
        REG_ROT_Z    = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_OFFSET_Z = 3'd6,
        REG_SCALE    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        quat_t                rot_w;
        quat_t                rot_x;
        quat_t                rot_y;
        quat_t                rot_z;
        coord_t               offset_x;
        coord_t               offset_y;
        coord_t               offset_z;
        logic [SCALE_W-1:0]   scale_factor;
    } cfg_t;

    localparam quat_t              ROT_W_RESET = QUAT_W'(16384);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(2048);

endpackage

>>> sv/quaternion_vertex_transform.sv
// Throughput: one vertex per cycle while m_axis_tready is high; six register
// stages, each with its own valid bit, hold in place under back-pressure and
// close up bubbles.
// Reset (aresetn low, synchronous): empty all stages and load the registers
// with identity rotation, zero offset and scale 0.5.
// Depends on qvt_pkg, qvt_cfg_regs, qvt_rotate and qvt_scale_out.
module quaternion_vertex_transform (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port, no read-back
    input  logic                                cfg_wr_en,
    input  logic [qvt_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [qvt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // vertex input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [qvt_pkg::TDATA_W-1:0]         s_axis_tdata,  // vertex_x, vertex_y, vertex_z
    input  logic                                s_axis_tlast,  // last_in
    // transformed vertex output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [qvt_pkg::TDATA_W-1:0]         m_axis_tdata,  // world_x, world_y, world_z
    output logic                                m_axis_tlast   // last_out
);

    localparam int CW = qvt_pkg::COORD_W;

    qvt_pkg::cfg_t   cfg;
    qvt_pkg::coord_t vtx [3];
    qvt_pkg::rot_t   rot [3];
    qvt_pkg::coord_t world [3];
    logic            rot_valid;
    logic            rot_ready;
    logic            rot_last;

    // The user must write config only with the pipeline drained; the block does
    // not enforce this. The stages read the live registers, not a per-word snapshot.
    qvt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // unpack the input word, x in the lowest bits
    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign vtx[i] = s_axis_tdata[i*CW +: CW];
    end

    // stages 1 to 4: rotation by the quaternion, result in units of 2^-12
    qvt_rotate u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .vtx_in    (vtx),
        .last_in   (s_axis_tlast),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .rot_out   (rot),
        .last_out  (rot_last)
    );

    // stages 5 and 6: scale, translate, round half up and saturate; the
    // last stage doubles as the output register
    qvt_scale_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .rot_in    (rot),
        .last_in   (rot_last),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .world     (world),
        .last_out  (m_axis_tlast)
    );

    // pack the result word, zero fill above the three coordinates
    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < 3; i++) begin
            m_axis_tdata[i*CW +: CW] = world[i];
        end
    end

endmodule

>>> sv/qvt_cfg_regs.sv
// Configuration register file: quaternion, offset and scale.
// Depends on qvt_pkg.
module qvt_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [qvt_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [qvt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output qvt_pkg::cfg_t                    cfg
);

    qvt_pkg::cfg_t cfg_reg;
    qvt_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (qvt_pkg::cfg_idx_t'(cfg_addr))
                qvt_pkg::REG_ROT_W:    cfg_next.rot_w    = cfg_wdata[qvt_pkg::QUAT_W-1:0];
                qvt_pkg::REG_ROT_X:    cfg_next.rot_x    = cfg_wdata[qvt_pkg::QUAT_W-1:0];
                qvt_pkg::REG_ROT_Y:    cfg_next.rot_y    = cfg_wdata[qvt_pkg::QUAT_W-1:0];
                qvt_pkg::REG_ROT_Z:    cfg_next.rot_z    = cfg_wdata[qvt_pkg::QUAT_W-1:0];
                qvt_pkg::REG_OFFSET_X: cfg_next.offset_x = cfg_wdata[qvt_pkg::COORD_W-1:0];
                qvt_pkg::REG_OFFSET_Y: cfg_next.offset_y = cfg_wdata[qvt_pkg::COORD_W-1:0];
                qvt_pkg::REG_OFFSET_Z: cfg_next.offset_z = cfg_wdata[qvt_pkg::COORD_W-1:0];
                qvt_pkg::REG_SCALE:    cfg_next.scale_factor = cfg_wdata[qvt_pkg::SCALE_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{rot_w:        qvt_pkg::ROT_W_RESET,
                         scale_factor: qvt_pkg::SCALE_RESET,
                         default:      '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/qvt_rotate.sv
// Four-stage rotation pipeline: t = 2*(q x v), then r = v + w*t + q x t.
// Depends on qvt_pkg.
module qvt_rotate (
    input  logic                aclk,
    input  logic                aresetn,
    input  qvt_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  qvt_pkg::coord_t     vtx_in [3],
    input  logic                last_in,
    output logic                out_valid,
    input  logic                out_ready,
    output qvt_pkg::rot_t       rot_out [3],
    output logic                last_out
);

    localparam int NSTG = 4;

    qvt_pkg::quat_t q [3];
    assign q[0] = cfg.rot_x;
    assign q[1] = cfg.rot_y;
    assign q[2] = cfg.rot_z;

    // per-stage handshake; a stage loads when empty or when it drains
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] vin;

    assign rdy[NSTG] = out_ready;
    assign vin[0]    = in_valid;
    for (genvar k = 0; k < NSTG; k++) begin : g_hs
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
        if (k > 0) begin : g_vin
            assign vin[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vin[k];
                end
            end
        end
    end

    // stage payloads
    logic signed [qvt_pkg::P1_W-1:0]  pa_reg [3];
    logic signed [qvt_pkg::P1_W-1:0]  pb_reg [3];
    logic signed [qvt_pkg::T_W-1:0]   t_reg  [3];
    logic signed [qvt_pkg::P2_W-1:0]  mw_reg [3];
    logic signed [qvt_pkg::P2_W-1:0]  ma_reg [3];
    logic signed [qvt_pkg::P2_W-1:0]  mb_reg [3];
    qvt_pkg::rot_t                    r_reg  [3];
    qvt_pkg::coord_t                  v0_reg [3];
    qvt_pkg::coord_t                  v1_reg [3];
    qvt_pkg::coord_t                  v2_reg [3];
    logic [NSTG-1:0]                  last_reg;

    logic signed [qvt_pkg::T_W-1:0]   t_next [3];
    qvt_pkg::rot_t                    r_next [3];

    for (genvar i = 0; i < 3; i++) begin : g_axis
        localparam int A = (i + 1) % 3;
        localparam int B = (i + 2) % 3;

        logic signed [qvt_pkg::C_W:0]     c_sum;
        logic signed [qvt_pkg::ACC_W-1:0] acc;

        always_comb begin
            c_sum = (qvt_pkg::C_W + 1)'(pa_reg[i]) - (qvt_pkg::C_W + 1)'(pb_reg[i])
                  + qvt_pkg::T_RND;
            t_next[i] = c_sum[qvt_pkg::C_W:qvt_pkg::T_SHIFT];
            acc = (qvt_pkg::ACC_W'(v2_reg[i]) <<< qvt_pkg::V_SHIFT)
                + qvt_pkg::ACC_W'(mw_reg[i])
                + qvt_pkg::ACC_W'(ma_reg[i])
                - qvt_pkg::ACC_W'(mb_reg[i])
                + qvt_pkg::R_RND;
            r_next[i] = acc[qvt_pkg::ACC_W-1:qvt_pkg::R_SHIFT];
        end

        always_ff @(posedge aclk) begin
            // stage 1: cross product terms
            if (rdy[0] && vin[0]) begin
                pa_reg[i] <= q[A] * vtx_in[B];
                pb_reg[i] <= q[B] * vtx_in[A];
                v0_reg[i] <= vtx_in[i];
            end
            // stage 2: round to t
            if (rdy[1] && vin[1]) begin
                t_reg[i]  <= t_next[i];
                v1_reg[i] <= v0_reg[i];
            end
            // stage 3: w*t and q x t terms
            if (rdy[2] && vin[2]) begin
                mw_reg[i] <= cfg.rot_w * t_reg[i];
                ma_reg[i] <= q[A] * t_reg[B];
                mb_reg[i] <= q[B] * t_reg[A];
                v2_reg[i] <= v1_reg[i];
            end
            // stage 4: accumulate and round to 2^-12
            if (rdy[3] && vin[3]) begin
                r_reg[i] <= r_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && vin[0]) begin
            last_reg[0] <= last_in;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (rdy[k] && vin[k]) begin
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign rot_out   = r_reg;
    assign last_out  = last_reg[NSTG-1];

endmodule

>>> sv/qvt_scale_out.sv
// Two-stage back end: multiply by scale, add offset, round and saturate.
// Depends on qvt_pkg.
module qvt_scale_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  qvt_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  qvt_pkg::rot_t       rot_in [3],
    input  logic                last_in,
    output logic                out_valid,
    input  logic                out_ready,
    output qvt_pkg::coord_t     world [3],
    output logic                last_out
);

    logic [1:0] vld_reg;
    logic [2:0] rdy;

    assign rdy[2] = out_ready;
    assign rdy[1] = !vld_reg[1] || rdy[2];
    assign rdy[0] = !vld_reg[0] || rdy[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            if (rdy[1]) vld_reg[1] <= vld_reg[0];
        end
    end

    qvt_pkg::coord_t off [3];
    assign off[0] = cfg.offset_x;
    assign off[1] = cfg.offset_y;
    assign off[2] = cfg.offset_z;

    logic signed [qvt_pkg::SCALE_W:0] sc;
    assign sc = $signed({1'b0, cfg.scale_factor});

    logic signed [qvt_pkg::SP_W-1:0] sp_reg [3];
    qvt_pkg::coord_t                 w_reg  [3];
    qvt_pkg::coord_t                 w_next [3];
    logic [1:0]                      last_reg;

    for (genvar i = 0; i < 3; i++) begin : g_axis
        logic signed [qvt_pkg::S_W-1:0] s_sum;
        logic signed [qvt_pkg::O_W-1:0] o_val;

        always_comb begin
            s_sum = qvt_pkg::S_W'(sp_reg[i])
                  + (qvt_pkg::S_W'(off[i]) <<< qvt_pkg::OFF_SHIFT)
                  + qvt_pkg::O_RND;
            o_val = s_sum[qvt_pkg::S_W-1:qvt_pkg::O_SHIFT];
            priority if (o_val > qvt_pkg::O_MAX) begin
                w_next[i] = qvt_pkg::O_MAX[qvt_pkg::COORD_W-1:0];
            end else if (o_val < qvt_pkg::O_MIN) begin
                w_next[i] = qvt_pkg::O_MIN[qvt_pkg::COORD_W-1:0];
            end else begin
                w_next[i] = o_val[qvt_pkg::COORD_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[0] && in_valid) begin
                sp_reg[i] <= rot_in[i] * sc;
            end
            if (rdy[1] && vld_reg[0]) begin
                w_reg[i] <= w_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) last_reg[0] <= last_in;
        if (rdy[1] && vld_reg[0]) last_reg[1] <= last_reg[0];
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[1];
    assign world     = w_reg;
    assign last_out  = last_reg[1];

endmodule

>>> sv/qvt_checker.sv
// Port-level checks for quaternion_vertex_transform, bound to the top level.
// Depends on qvt_pkg for the word width.
module qvt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [qvt_pkg::TDATA_W-1:0]   m_axis_tdata,
    input logic                          m_axis_tlast
);

    // a stalled result word stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result word offered straight after reset");

    // input can only back up when a finished word waits at the output
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result word");

endmodule

bind quaternion_vertex_transform qvt_checker u_qvt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/tb_quaternion_vertex_transform.sv
// Self-checking bench for quaternion_vertex_transform: streams vertices through
// the block and compares every output word with a predictor kept in step here.
// Depends on qvt_pkg and the RTL of quaternion_vertex_transform only.
`timescale 1ns / 100ps

module tb_quaternion_vertex_transform;
    import qvt_pkg::*;

    localparam int          CLK_HALF    = 6;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 20;   // ample slack for the pipeline to drain
    localparam int          LONG_HOLD   = 300;
    localparam int          RANDOM_RUNS = 8;
    localparam int          RUN_WORDS   = 200;
    localparam int          REPORT_CAP  = 50;
    localparam logic [15:0] Q14_ONE     = 16'd16384;
    localparam logic [15:0] Q12_ONE     = 16'd4096;
    localparam logic [15:0] COS_45      = 16'd11585;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
    } vertex_t;

    typedef enum int {
        SET_SATURATE,
        SET_FLOOR,
        SET_QUARTER_TURN,
        SET_BOUNDED,
        SET_RAW,
        SET_UNIT_SCALE
    } settings_kind_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;  // vertex_x, vertex_y, vertex_z
    logic                  s_axis_tlast  = 1'b0; // last_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;         // world_x, world_y, world_z
    logic                  m_axis_tlast;         // last_out

    // register image the predictor works from, updated as each write lands
    logic [15:0] reg_shadow [8];

    vertex_t vertex_queue[$];     // words waiting for the driver
    vertex_t world_expect_q[$];   // predicted output words, oldest first

    int  mismatch_count  = 0;
    int  words_out       = 0;
    int  send_idle_pct   = 0;
    int  recv_stall_pct  = 0;
    bit  send_pause      = 1'b0;
    int  hold_request_seq = 0;
    int  hold_seen_seq   = 0;
    int  hold_left       = 0;
    int  mesh_left       = 0;
    bit  in_taken        = 1'b0;
    bit  results_settled = 1'b1;
    bit  pipeline_idle   = 1'b1;

    quaternion_vertex_transform dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // round half up: floor((a + 2^(sh-1)) / 2^sh); >>> on a signed longint floors
    function automatic longint round_half_up(longint a, int sh);
        return (a + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic vertex_t unpack_word(logic [TDATA_W-1:0] data, logic last);
        vertex_t v;
        v.x    = data[0 +: COORD_W];
        v.y    = data[COORD_W +: COORD_W];
        v.z    = data[2*COORD_W +: COORD_W];
        v.last = last;
        return v;
    endfunction

    // position + scale * rotate(vertex), worked in the same fixed-point steps
    // as the hardware: t = 2*(q x v) to 2^-12, r = v + w*t + q x t to 2^-12,
    // then scale, add offset, round to 2^-8 and clamp to the coordinate width
    function automatic vertex_t transform_vertex(vertex_t v_in);
        longint  vec [3];
        longint  q [3];
        longint  off [3];
        longint  t [3];
        longint  r [3];
        longint  res [3];
        longint  w;
        longint  sc;
        longint  acc;
        longint  o;
        longint  hi;
        longint  lo;
        int      a;
        int      b;
        vertex_t out;
        hi = (longint'(1) <<< (COORD_W - 1)) - 1;
        lo = -(longint'(1) <<< (COORD_W - 1));
        vec[0] = v_in.x;
        vec[1] = v_in.y;
        vec[2] = v_in.z;
        w  = $signed(reg_shadow[REG_ROT_W]);
        sc = reg_shadow[REG_SCALE];
        for (int i = 0; i < 3; i++) begin
            q[i]   = $signed(reg_shadow[REG_ROT_X + i]);
            off[i] = $signed(reg_shadow[REG_OFFSET_X + i]);
        end
        for (int i = 0; i < 3; i++) begin
            a = (i + 1) % 3;
            b = (i + 2) % 3;
            t[i] = round_half_up(2 * (q[a] * vec[b] - q[b] * vec[a]), 10);
        end
        for (int i = 0; i < 3; i++) begin
            a = (i + 1) % 3;
            b = (i + 2) % 3;
            acc = (vec[i] <<< 18) + w * t[i] + q[a] * t[b] - q[b] * t[a];
            r[i] = round_half_up(acc, 14);
        end
        for (int i = 0; i < 3; i++) begin
            o = round_half_up(r[i] * sc + (off[i] <<< 16), 16);
            res[i] = (o > hi) ? hi : ((o < lo) ? lo : o);
        end
        out.x    = coord_t'(res[0]);
        out.y    = coord_t'(res[1]);
        out.z    = coord_t'(res[2]);
        out.last = v_in.last;
        return out;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < REPORT_CAP)
            $display("ERROR %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued vertices at the falling edge, hold a word
    // until it is taken, idle at random between words
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_vertices
        vertex_t next_v;
        bit      give;
        if (aresetn && (!s_axis_tvalid || in_taken)) begin
            give = (vertex_queue.size() != 0) && !send_pause &&
                   ($urandom_range(0, 99) >= send_idle_pct);
            if (give) begin
                next_v = vertex_queue.pop_front();
                s_axis_tdata <= {next_v.z, next_v.y, next_v.x};
                s_axis_tlast <= next_v.last;
            end
            s_axis_tvalid <= give;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off counted here whenever
    // the stimulus bumps the request count
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen_seq != hold_request_seq) begin
            hold_seen_seq = hold_request_seq;
            hold_left     = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted input word, check each output
    // word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_world
        vertex_t got;
        vertex_t want;
        in_taken = s_axis_tvalid && s_axis_tready;
        if (in_taken)
            world_expect_q.push_back(transform_vertex(unpack_word(s_axis_tdata, s_axis_tlast)));
        if (m_axis_tvalid && m_axis_tready) begin
            got = unpack_word(m_axis_tdata, m_axis_tlast);
            if (world_expect_q.size() == 0) begin
                report_mismatch($sformatf("word %0d arrived with nothing expected", words_out));
            end else begin
                want = world_expect_q.pop_front();
                if (got.x !== want.x)
                    report_mismatch($sformatf("word %0d world_x got %0d expected %0d",
                                              words_out, got.x, want.x));
                if (got.y !== want.y)
                    report_mismatch($sformatf("word %0d world_y got %0d expected %0d",
                                              words_out, got.y, want.y));
                if (got.z !== want.z)
                    report_mismatch($sformatf("word %0d world_z got %0d expected %0d",
                                              words_out, got.z, want.z));
                if (got.last !== want.last)
                    report_mismatch($sformatf("word %0d last_out got %0b expected %0b",
                                              words_out, got.last, want.last));
            end
            words_out++;
        end
        results_settled = (world_expect_q.size() == 0) && !s_axis_tvalid;
        pipeline_idle   = results_settled && (vertex_queue.size() == 0);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // one register per rising edge; the caller drops the enable afterwards
    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        reg_shadow[idx] = value;
    endtask

    task automatic apply_settings(settings_kind_t kind);
        logic [15:0] rot [4];   // w, x, y, z
        logic [15:0] off [3];
        logic [15:0] scale;
        int          axis;
        case (kind)
            SET_SATURATE: begin
                // raw values outside the stated range, full scale: drive saturation
                rot   = '{default: 16'h8000};
                off   = '{default: 16'h7fff};
                scale = 16'hffff;
            end
            SET_FLOOR: begin
                rot   = '{default: 16'h7fff};
                off   = '{default: 16'h8000};
                scale = 16'h0000;
            end
            SET_QUARTER_TURN: begin
                rot    = '{default: 16'h0000};
                rot[0] = COS_45;
                axis   = $urandom_range(1, 3);
                rot[axis] = $urandom_range(0, 1) ? COS_45 : -COS_45;
                for (int i = 0; i < 3; i++)
                    off[i] = 16'($urandom_range(0, 8192)) - 16'd4096;
                scale = Q12_ONE;
            end
            SET_BOUNDED: begin
                // components anywhere in range, so mostly not unit length
                for (int i = 0; i < 4; i++)
                    rot[i] = 16'($urandom_range(0, 32768)) - Q14_ONE;
                for (int i = 0; i < 3; i++)
                    off[i] = 16'($urandom);
                scale = 16'($urandom_range(1024, 8192));
            end
            SET_RAW: begin
                for (int i = 0; i < 4; i++)
                    rot[i] = 16'($urandom);
                for (int i = 0; i < 3; i++)
                    off[i] = 16'($urandom);
                scale = 16'($urandom);
            end
            default: begin
                rot    = '{default: 16'h0000};
                rot[0] = Q14_ONE;
                for (int i = 0; i < 3; i++)
                    off[i] = 16'($urandom);
                scale = Q12_ONE;
            end
        endcase
        write_reg(REG_ROT_W,    rot[0]);
        write_reg(REG_ROT_X,    rot[1]);
        write_reg(REG_ROT_Y,    rot[2]);
        write_reg(REG_ROT_Z,    rot[3]);
        write_reg(REG_OFFSET_X, off[0]);
        write_reg(REG_OFFSET_Y, off[1]);
        write_reg(REG_OFFSET_Z, off[2]);
        write_reg(REG_SCALE,    scale);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_vertex(int x, int y, int z, bit last);
        vertex_t v;
        v.x    = coord_t'(x);
        v.y    = coord_t'(y);
        v.z    = coord_t'(z);
        v.last = last;
        vertex_queue.push_back(v);
    endtask

    // meshes of random length; a quarter of the coordinates stay near the
    // origin, the rest cover the whole range
    task automatic add_random_vertex();
        int c [3];
        for (int i = 0; i < 3; i++)
            c[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) - 512
                                               : int'($urandom);
        if (mesh_left == 0)
            mesh_left = $urandom_range(1, 40);
        mesh_left--;
        add_vertex(c[0], c[1], c[2], mesh_left == 0);
    endtask

    // whole = wait for an empty queue too, else only for outstanding results
    task automatic wait_quiet(bit whole);
        @(posedge aclk);
        @(negedge aclk);
        while (!(whole ? pipeline_idle : results_settled))
            @(negedge aclk);
    endtask

    task automatic set_traffic(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("ERROR: no progress within %0d cycles", CYCLE_LIMIT);
        $display("quaternion_vertex_transform: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed runs under fixed settings, then random runs
    // cycling through the traffic modes
    // ------------------------------------------------------------------
    initial begin : run_stimulus
        settings_kind_t plan [RANDOM_RUNS];
        plan = '{SET_BOUNDED, SET_RAW, SET_QUARTER_TURN, SET_BOUNDED,
                 SET_RAW, SET_UNIT_SCALE, SET_BOUNDED, SET_QUARTER_TURN};

        for (int i = 0; i < 8; i++)
            reg_shadow[i] = 16'h0000;
        reg_shadow[REG_ROT_W] = ROT_W_RESET;
        reg_shadow[REG_SCALE] = SCALE_RESET;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: identity rotation, scale one half; extremes and
        // rounding of odd values
        @(posedge aclk);
        add_vertex(0, 0, 0, 1'b0);
        add_vertex(32767, 32767, 32767, 1'b0);
        add_vertex(-32768, -32768, -32768, 1'b0);
        add_vertex(1, -1, 3, 1'b0);
        add_vertex(-3, 5, -7, 1'b0);
        add_vertex(32767, -32768, 0, 1'b0);
        add_vertex(-32768, 0, 32767, 1'b0);
        add_vertex(256, 512, -256, 1'b1);
        wait_quiet(1'b1);

        // out-of-range quaternion, full scale, top offset: saturate both ways
        apply_settings(SET_SATURATE);
        @(posedge aclk);
        add_vertex(0, 0, 0, 1'b0);
        add_vertex(1, 2, 3, 1'b0);
        add_vertex(32767, -32768, 100, 1'b0);
        add_vertex(-1, -1, -1, 1'b0);
        add_vertex(-32768, 32767, -32768, 1'b1);
        wait_quiet(1'b1);

        // zero scale leaves only the bottom offset
        apply_settings(SET_FLOOR);
        @(posedge aclk);
        add_vertex(0, 0, 0, 1'b0);
        add_vertex(32767, 32767, 32767, 1'b1);
        wait_quiet(1'b1);

        // quarter turn about one axis at unit scale: unit vectors swap axes
        apply_settings(SET_QUARTER_TURN);
        @(posedge aclk);
        add_vertex(256, 0, 0, 1'b0);
        add_vertex(0, 256, 0, 1'b0);
        add_vertex(0, 0, 256, 1'b0);
        add_vertex(300, -700, 1234, 1'b1);
        wait_quiet(1'b1);

        for (int run = 0; run < RANDOM_RUNS; run++) begin
            apply_settings(plan[run]);
            @(posedge aclk);
            case (run % 4)
                0:       set_traffic(0, 0);
                1:       set_traffic(56, 0);
                2:       set_traffic(0, 56);
                default: set_traffic(8, 8);
            endcase
            repeat (RUN_WORDS) add_random_vertex();
            // hold the receiver off while words keep coming: fill the pipe
            if (run == 0)
                hold_request_seq++;
            // stop sending midway and let every pending result come out
            if (run == 2) begin
                do @(posedge aclk); while (vertex_queue.size() > RUN_WORDS / 2);
                send_pause = 1'b1;
                wait_quiet(1'b0);
                @(posedge aclk);
                send_pause = 1'b0;
            end
            wait_quiet(1'b1);
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0)
            $display("quaternion_vertex_transform: match");
        else
            $display("quaternion_vertex_transform: mismatch");
        $finish;
    end

endmodule
